/* rtl/pref_pkg.sv */
package pref_pkg;

    localparam logic [5:0]  SSID_MAX      = 6'd32;
    localparam logic [5:0]  POS_MAX       = 6'd63;
    localparam logic [5:0]  MAC_FIRST_POS = 6'd10;
    localparam logic [5:0]  MAC_LAST_POS  = 6'd15;
    localparam logic [5:0]  TAG_POS       = 6'd24;
    localparam logic [5:0]  LEN_POS       = 6'd25;
    localparam logic [15:0] MIN_FRAME_LEN = 16'd26;
    localparam logic [7:0]  FC_TYPE_MASK  = 8'hF0;
    localparam logic [7:0]  FC_PROBE_REQ  = 8'h40;
    localparam logic [7:0]  SSID_TAG      = 8'h00;

    typedef enum logic {
        KIND_HEADER = 1'b0,
        KIND_SSID   = 1'b1
    } pref_kind_t;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic              end_of_frame;
        logic [15:0]       frame_length;
        logic              is_management;
        logic signed [7:0] rssi_in;
        logic [3:0]        channel_in;
        logic [31:0]       uptime_seconds;
    } pref_in_t;

    typedef struct packed {
        pref_kind_t        result_kind;
        logic [47:0]       source_mac;
        logic [5:0]        ssid_length;
        logic signed [7:0] rssi_out;
        logic [3:0]        channel_out;
        logic [31:0]       timestamp_out;
        logic [7:0]        ssid_byte;
        logic              last_of_run;
    } pref_out_t;

endpackage

/* rtl/probe_request_field_extractor.sv */
// Probe request field extractor.
// item channel: one frame byte per beat (item_valid/item_ready) with the
// frame metadata alongside; end_of_frame marks the final byte.
// result channel: per accepted frame, one header beat (source MAC, SSID
// length, RSSI, channel, timestamp), then one beat per SSID byte; the final
// beat of a complete run carries last_of_run. Rejected frames give nothing.
// A byte in the input register writes its result, if any, into the result
// register as it advances. Throughput: one byte per cycle without stalls.
// An input register holds the byte while the position compare and capture
// run; the result register stands between that logic and the receiver.
// When the receiver stalls, the result register holds and the input
// register fills; item_ready drops only when both are occupied, and resumes
// in the cycle the result beat is taken.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// frame parser to the start of a frame.
module probe_request_field_extractor
    import pref_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  pref_in_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output pref_out_t result
);

    logic      stage_valid_reg;
    pref_in_t  stage_reg;
    logic      result_valid_reg;
    pref_out_t result_reg;

    logic [5:0]  byte_position_reg;
    logic        frame_rejected_reg;
    logic [47:0] captured_mac_reg;
    logic        ssid_tag_seen_reg;
    logic [5:0]  ssid_bytes_left_reg;

    logic [5:0]  byte_position_next;
    logic        frame_rejected_next;
    logic [47:0] captured_mac_next;
    logic        ssid_tag_seen_next;
    logic [5:0]  ssid_bytes_left_next;

    logic      emit;
    pref_out_t emit_data;
    logic      advance;
    logic      reject_now;
    logic [5:0] len_clamped;
    logic [5:0] len_final;
    logic [5:0] left_dec;

    // stage consumes its byte whenever the result register is free this cycle
    assign advance    = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || advance;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        reject_now = frame_rejected_reg;
        if (byte_position_reg == '0)
        begin
            if (!stage_reg.is_management || stage_reg.frame_length < MIN_FRAME_LEN ||
                (stage_reg.data_byte & FC_TYPE_MASK) != FC_PROBE_REQ)
            begin
                reject_now = 1'b1;
            end
        end

        if (stage_reg.data_byte > {2'b00, SSID_MAX})
            len_clamped = SSID_MAX;
        else
            len_clamped = stage_reg.data_byte[5:0];

        len_final = '0;
        if (ssid_tag_seen_reg &&
            ({11'd0, len_clamped} + 17'd26) <= {1'b0, stage_reg.frame_length})
        begin
            len_final = len_clamped;
        end

        left_dec = ssid_bytes_left_reg - 6'd1;

        frame_rejected_next  = reject_now;
        captured_mac_next    = captured_mac_reg;
        ssid_tag_seen_next   = ssid_tag_seen_reg;
        ssid_bytes_left_next = ssid_bytes_left_reg;
        emit                 = 1'b0;
        emit_data            = '0;

        if (!reject_now)
        begin
            if (byte_position_reg >= MAC_FIRST_POS &&
                byte_position_reg <= MAC_LAST_POS)
            begin
                captured_mac_next = {captured_mac_reg[39:0], stage_reg.data_byte};
            end
            else if (byte_position_reg == TAG_POS)
            begin
                ssid_tag_seen_next = (stage_reg.data_byte == SSID_TAG);
            end
            else if (byte_position_reg == LEN_POS)
            begin
                ssid_bytes_left_next    = len_final;
                emit                    = 1'b1;
                emit_data.result_kind   = KIND_HEADER;
                emit_data.source_mac    = captured_mac_reg;
                emit_data.ssid_length   = len_final;
                emit_data.rssi_out      = stage_reg.rssi_in;
                emit_data.channel_out   = stage_reg.channel_in;
                emit_data.timestamp_out = stage_reg.uptime_seconds;
                emit_data.last_of_run   = (len_final == '0);
            end
            else if (byte_position_reg > LEN_POS && ssid_bytes_left_reg != '0)
            begin
                ssid_bytes_left_next  = left_dec;
                emit                  = 1'b1;
                emit_data.result_kind = KIND_SSID;
                emit_data.ssid_byte   = stage_reg.data_byte;
                emit_data.last_of_run = (left_dec == '0);
            end
        end

        byte_position_next = byte_position_reg;
        if (byte_position_reg < POS_MAX)
            byte_position_next = byte_position_reg + 6'd1;

        if (stage_reg.end_of_frame)
        begin
            byte_position_next   = '0;
            frame_rejected_next  = 1'b0;
            captured_mac_next    = '0;
            ssid_tag_seen_next   = 1'b0;
            ssid_bytes_left_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg     <= 1'b0;
            result_valid_reg    <= 1'b0;
            byte_position_reg   <= '0;
            frame_rejected_reg  <= 1'b0;
            captured_mac_reg    <= '0;
            ssid_tag_seen_reg   <= 1'b0;
            ssid_bytes_left_reg <= '0;
        end
        else
        begin
            if (item_ready)
                stage_valid_reg <= item_valid;

            if (advance)
            begin
                byte_position_reg   <= byte_position_next;
                frame_rejected_reg  <= frame_rejected_next;
                captured_mac_reg    <= captured_mac_next;
                ssid_tag_seen_reg   <= ssid_tag_seen_next;
                ssid_bytes_left_reg <= ssid_bytes_left_next;
                result_valid_reg    <= emit;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            stage_reg <= item;
        if (advance && emit)
            result_reg <= emit_data;
    end

    a_empty_ssid_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.result_kind == KIND_HEADER && result.ssid_length == '0
        |-> result.last_of_run)
        else $error("header with empty SSID lacks last_of_run");

    a_ssid_beat_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.result_kind == KIND_SSID
        |-> result.source_mac == '0 && result.ssid_length == '0 &&
            result.timestamp_out == '0)
        else $error("SSID beat carries header fields");

    a_left_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ssid_bytes_left_reg <= SSID_MAX)
        else $error("SSID count above maximum");

    a_rejected_silent: assert property (@(posedge clk) disable iff (!rst_n)
        frame_rejected_reg |-> ssid_bytes_left_reg == '0 && !ssid_tag_seen_reg)
        else $error("rejected frame holds SSID state");

endmodule

/* verif/tb_top.sv */
import pref_pkg::*;

// Tracks the parser state for each accepted byte and keeps the records the
// block owes the receiver, oldest first.
class probe_record_board;
    logic [5:0]  position;
    logic        rejected;
    logic [47:0] mac_shift;
    logic        ssid_tag_zero;
    logic [5:0]  ssid_remaining;
    pref_out_t   awaited_records[$];
    int          failures;

    function new();
        clear_frame();
        failures = 0;
    endfunction

    function void clear_frame();
        position       = '0;
        rejected       = 1'b0;
        mac_shift      = '0;
        ssid_tag_zero  = 1'b0;
        ssid_remaining = '0;
    endfunction

    function void parse_byte(pref_in_t beat);
        pref_out_t rec;
        int        len;
        rec = '0;
        if (position == '0)
        begin
            if (!beat.is_management || beat.frame_length < MIN_FRAME_LEN
                    || (beat.data_byte & FC_TYPE_MASK) != FC_PROBE_REQ)
                rejected = 1'b1;
        end
        if (!rejected)
        begin
            if (position >= MAC_FIRST_POS && position <= MAC_LAST_POS)
                mac_shift = {mac_shift[39:0], beat.data_byte};
            else if (position == TAG_POS)
                ssid_tag_zero = (beat.data_byte == SSID_TAG);
            else if (position == LEN_POS)
            begin
                len = 0;
                if (ssid_tag_zero)
                begin
                    len = int'(beat.data_byte);
                    if (len > int'(SSID_MAX))
                        len = int'(SSID_MAX);
                    // SSID must fit inside the declared frame length
                    if (int'(MIN_FRAME_LEN) + len > int'(beat.frame_length))
                        len = 0;
                end
                ssid_remaining    = len[5:0];
                rec.result_kind   = KIND_HEADER;
                rec.source_mac    = mac_shift;
                rec.ssid_length   = len[5:0];
                rec.rssi_out      = beat.rssi_in;
                rec.channel_out   = beat.channel_in;
                rec.timestamp_out = beat.uptime_seconds;
                rec.last_of_run   = (len == 0);
                awaited_records.push_back(rec);
            end
            else if (position > LEN_POS && ssid_remaining != '0)
            begin
                ssid_remaining  = ssid_remaining - 6'd1;
                rec.result_kind = KIND_SSID;
                rec.ssid_byte   = beat.data_byte;
                rec.last_of_run = (ssid_remaining == '0);
                awaited_records.push_back(rec);
            end
        end
        if (position != POS_MAX)
            position = position + 6'd1;
        if (beat.end_of_frame)
            clear_frame();
    endfunction

    function string describe(pref_out_t r);
        return $sformatf("kind=%0d mac=%h len=%0d rssi=%0d ch=%0d ts=%h ssid=%h last=%b",
                         r.result_kind, r.source_mac, r.ssid_length, r.rssi_out,
                         r.channel_out, r.timestamp_out, r.ssid_byte, r.last_of_run);
    endfunction

    function void note_failure(string msg);
        failures++;
        if (failures <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    function void compare_record(pref_out_t got);
        pref_out_t want;
        if (awaited_records.size() == 0)
        begin
            note_failure({"unexpected result beat: ", describe(got)});
            return;
        end
        want = awaited_records.pop_front();
        if (got.result_kind !== want.result_kind || got.source_mac !== want.source_mac
                || got.ssid_length !== want.ssid_length || got.rssi_out !== want.rssi_out
                || got.channel_out !== want.channel_out
                || got.timestamp_out !== want.timestamp_out
                || got.ssid_byte !== want.ssid_byte || got.last_of_run !== want.last_of_run)
            note_failure({"result mismatch\n  expected ", describe(want),
                          "\n  actual   ", describe(got)});
    endfunction
endclass

module tb_top;

    typedef struct {
        int unsigned       n_bytes;
        logic [15:0]       flen;
        logic              mgmt;
        logic [7:0]        fc;
        logic [7:0]        tag;
        logic [7:0]        len_byte;
        logic [47:0]       mac;
        logic signed [7:0] rssi;
        logic [3:0]        chan;
        logic [31:0]       secs;
        bit                meta_noise;
    } frame_plan_t;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    pref_in_t  item;
    logic      result_valid;
    logic      result_ready;
    pref_out_t result;

    probe_record_board board = new();
    int unsigned       bytes_driven = 0;
    bit                sender_calm  = 1'b0;

    probe_request_field_extractor i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #800000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // Well-formed probe request: tag 0, length byte as given, frame sized to fit.
    function automatic frame_plan_t probe_plan(int unsigned req_len, int unsigned tail);
        frame_plan_t p;
        int unsigned fit;
        fit          = (req_len > SSID_MAX) ? SSID_MAX : req_len;
        p.fc         = FC_PROBE_REQ | 8'($urandom & 32'h0F);
        p.len_byte   = 8'(req_len);
        p.n_bytes    = int'(MIN_FRAME_LEN) + fit + tail;
        p.flen       = 16'(p.n_bytes);
        p.mgmt       = 1'b1;
        p.tag        = SSID_TAG;
        p.mac        = 48'({$urandom, $urandom});
        p.rssi       = 8'($urandom);
        p.chan       = 4'($urandom);
        p.secs       = $urandom;
        p.meta_noise = 1'b0;
        return p;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic drive_byte(pref_in_t beat);
        int gap;
        gap = draw_gap(sender_calm);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        do @(posedge clk); while (!item_ready);
        board.parse_byte(beat);
        bytes_driven++;
        @(negedge clk);
    endtask

    task automatic send_frame(frame_plan_t p);
        pref_in_t    beat;
        int unsigned idx;
        if ($urandom_range(0, 3) == 0)
            sender_calm = !sender_calm;
        for (idx = 0; idx < p.n_bytes; idx++)
        begin
            beat.frame_length   = p.flen;
            beat.is_management  = p.mgmt;
            beat.rssi_in        = p.rssi;
            beat.channel_in     = p.chan;
            beat.uptime_seconds = p.secs;
            if (p.meta_noise && idx != 0 && $urandom_range(0, 2) == 0)
            begin
                beat.frame_length   = 16'($urandom);
                beat.is_management  = 1'($urandom);
                beat.rssi_in        = 8'($urandom);
                beat.channel_in     = 4'($urandom);
                beat.uptime_seconds = $urandom;
            end
            if (idx == 0)
                beat.data_byte = p.fc;
            else if (idx >= MAC_FIRST_POS && idx <= MAC_LAST_POS)
                beat.data_byte = p.mac[8 * (15 - idx) +: 8];
            else if (idx == TAG_POS)
                beat.data_byte = p.tag;
            else if (idx == LEN_POS)
                beat.data_byte = p.len_byte;
            else
                beat.data_byte = 8'($urandom);
            beat.end_of_frame = (idx == p.n_bytes - 1);
            drive_byte(beat);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.compare_record(result);
    end

    // Receiver: random stalls, calm stretches, and one long hold-off early on
    // so the input side backs up while the sender keeps offering bytes.
    initial
    begin : result_sink
        int stall;
        int beats;
        bit calm;
        beats        = 0;
        calm         = 1'b0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (beats == 60)
            begin
                result_ready <= 1'b0;
                repeat (120) @(negedge clk);
            end
            stall = draw_gap(calm);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            beats++;
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
        end
    end

    initial
    begin : stimulus
        frame_plan_t p;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty SSID at the minimum length, low extremes of the metadata
        p = probe_plan(0, 0);
        p.rssi = -8'sd128; p.chan = 4'd0; p.secs = 32'h0; p.mac = '0;
        send_frame(p);
        // length byte 255 clamps, high extremes
        p = probe_plan(255, 2);
        p.rssi = 8'sd127; p.chan = 4'hF; p.secs = 32'hFFFF_FFFF; p.mac = '1;
        p.flen = 16'hFFFF; p.fc = FC_PROBE_REQ | 8'h0F;
        send_frame(p);
        // exact fit of a maximal SSID
        send_frame(probe_plan(32, 0));
        // SSID would run past the frame length
        p = probe_plan(10, 3);
        p.flen = 16'd35;
        send_frame(p);
        // tag other than SSID
        p = probe_plan(4, 4);
        p.tag = 8'h01;
        send_frame(p);
        // not a management frame
        p = probe_plan(3, 0);
        p.mgmt = 1'b0;
        send_frame(p);
        // declared length below the minimum
        p = probe_plan(3, 0);
        p.flen = MIN_FRAME_LEN - 16'd1;
        send_frame(p);
        // wrong frame control subtype
        p = probe_plan(3, 0);
        p.fc = 8'h50;
        send_frame(p);
        // short frame, ends before the header
        p = probe_plan(3, 0);
        p.n_bytes = 12;
        send_frame(p);
        // frame ends inside the SSID
        p = probe_plan(10, 0);
        p.n_bytes = 30;
        p.flen = 16'd40;
        send_frame(p);
        // long frame, position saturates
        send_frame(probe_plan(20, 30));
        // metadata churning within a frame
        p = probe_plan(6, 2);
        p.meta_noise = 1'b1;
        send_frame(p);
        // single-byte frame
        p = probe_plan(0, 0);
        p.n_bytes = 1;
        send_frame(p);

        while (bytes_driven < 650)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                p = probe_plan(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 20),
                               $urandom_range(0, 6));
                case ($urandom_range(0, 9))
                    0: p.meta_noise = 1'b1;
                    1: p.flen = 16'($urandom);
                    2: p.n_bytes = $urandom_range(20, p.n_bytes);
                    3: p.tag = 8'($urandom_range(1, 255));
                    default: ;
                endcase
            end
            else
            begin
                p = probe_plan($urandom_range(0, 255), $urandom_range(0, 6));
                p.fc         = 8'($urandom);
                p.mgmt       = 1'($urandom);
                p.flen       = 16'($urandom);
                p.tag        = 8'($urandom);
                p.n_bytes    = $urandom_range(1, 40);
                p.meta_noise = 1'($urandom);
            end
            send_frame(p);
        end
        item_valid <= 1'b0;

        while (board.awaited_records.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
rtl/pref_pkg.sv
rtl/probe_request_field_extractor.sv
verif/tb_top.sv
